@@ rtl/u2a_pkg.sv @@
// Shared types, constants and helpers for the unsigned-to-ASCII formatter.
// No dependencies; used by u2a_dabble and unsigned_to_ascii_formatter.
`timescale 1ns / 1ps

package u2a_pkg;

	// Width of the binary number to convert
	localparam int VALUE_WIDTH = 32;

	// Decimal digits needed for VALUE_WIDTH bits (1233/4096 ~ log10(2))
	localparam int MAX_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int DIG_W      = MAX_DIGITS * 4;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int STEP_W     = $clog2(VALUE_WIDTH + 1);

	// Fixed-point overflow bound (tenths)
	localparam int unsigned FIX_LIMIT = 9999;
	localparam int FIX_W = 14;
	localparam int EXT_W = VALUE_WIDTH + FIX_W;

	// Overflow text "*.***": length and position of the dot, counted down
	localparam int OVF_LEN     = 5;
	localparam int OVF_DOT_POS = 3;

	// Format selector codes
	localparam logic [1:0] FUNC_DEC = 2'd0;
	localparam logic [1:0] FUNC_HEX = 2'd1;
	localparam logic [1:0] FUNC_FIX = 2'd2;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_STAR = 8'h2A;

	typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT,
		ST_OVF
	} state_t;

	// Control from the sequencer to the shift-add-3 unit
	typedef struct packed {
		logic load_bin;   // start a binary-to-BCD conversion
		logic load_hex;   // load the value straight in as nibbles
		logic shift;      // one correct-and-shift step
	} dab_ctl_t;

	// One digit (0..15) to its ASCII character, upper-case hex
	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		if (d < 4'd10)
			return CHAR_ZERO + d8;
		else
			return CHAR_A + d8 - 8'd10;
	endfunction

	// True when a fixed-point value exceeds the printable range
	function automatic logic fix_over(input logic [VALUE_WIDTH-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = {{FIX_W{1'b0}}, v};
		return ext > EXT_W'(FIX_LIMIT);
	endfunction

endpackage

@@ rtl/u2a_dabble.sv @@
// Shared shift-add-3 unit: binary to BCD, one input bit per step.
// Also holds hex nibbles loaded directly. Depends on u2a_pkg.
`timescale 1ns / 1ps

module u2a_dabble (
	input  logic                                clk,
	input  u2a_pkg::dab_ctl_t                   ctl,
	input  logic [u2a_pkg::VALUE_WIDTH-1:0]     value,
	output u2a_pkg::digits_t                    digits
);

	localparam int VW     = u2a_pkg::VALUE_WIDTH;
	localparam int NDIG   = u2a_pkg::MAX_DIGITS;
	localparam int DW     = u2a_pkg::DIG_W;

	logic [VW-1:0]      bin_q;
	u2a_pkg::digits_t   bcd_q;
	u2a_pkg::digits_t   adj;
	logic [DW-1:0]      adj_flat;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] >= 4'd5)
				adj[i] = bcd_q[i] + 4'd3;
			else
				adj[i] = bcd_q[i];
		end
		adj_flat = adj;
	end

	// Working registers; payload only, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load_bin) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctl.load_hex) begin
			bcd_q <= {{(DW-VW){1'b0}}, value};
		end else if (ctl.shift) begin
			bin_q <= {bin_q[VW-2:0], 1'b0};
			bcd_q <= {adj_flat[DW-2:0], bin_q[VW-1]};
		end
	end

	assign digits = bcd_q;

endmodule

@@ rtl/unsigned_to_ascii_formatter.sv @@
// Top level of the unsigned-to-ASCII formatter: sequencer and output register.
// Depends on u2a_pkg and u2a_dabble.
//
// Usage:
//   Input channel (in_valid/in_ready): func selects decimal (0), upper-case
//   hex (1) or fixed point in tenths (2); value is the 32-bit number.
//   A transfer with func 3 is taken and produces no characters.
//   Output channel (out_valid/out_ready): one ASCII character per transfer,
//   most significant first, no padding; last marks the final character.
// Sequence:
//   Decimal and fixed: load, one shift-add-3 step per input bit, scan, then
//   one character per cycle unless stalled (up to 10; up to 5 in fixed mode).
//   Hex: a load step, a scan step, then up to 8 characters.
//   Fixed overflow ("*.***"): 5 characters right after the transfer.
//   The single shared BCD unit converts one bit a step.
//   in_ready is high only while idle; the next item can be taken while the
//   final character still sits in the output register.
// Reset: arst_n clears the sequencer and the output valid flag.
// Stall: a low out_ready holds the character and pauses character emission.
`timescale 1ns / 1ps

module unsigned_to_ascii_formatter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [u2a_pkg::VALUE_WIDTH-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      char_code,
	output logic                            last
);

	localparam int VW     = u2a_pkg::VALUE_WIDTH;
	localparam int NDIG   = u2a_pkg::MAX_DIGITS;
	localparam int IDX_W  = u2a_pkg::IDX_W;
	localparam int STEP_W = u2a_pkg::STEP_W;

	u2a_pkg::state_t    state_q, state_d;
	logic [STEP_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               fix_q, fix_d;
	logic               dot_q, dot_d;

	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;

	u2a_pkg::dab_ctl_t  ctl;
	u2a_pkg::digits_t   digits;
	logic [IDX_W-1:0]   hi;
	logic               advance;
	logic               push;
	logic [7:0]         push_char;
	logic               push_last;

	u2a_dabble u_dabble (
		.clk    (clk),
		.ctl    (ctl),
		.value  (value),
		.digits (digits)
	);

	// Output slot is free or being emptied this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = (state_q == u2a_pkg::ST_IDLE);

	// Highest nonzero digit; fixed mode keeps at least one integer digit
	always_comb begin
		hi = '0;
		for (int i = 1; i < NDIG; i++) begin
			if (digits[i] != 4'd0)
				hi = IDX_W'(i);
		end
		if (fix_q && hi == '0)
			hi = IDX_W'(1);
	end

	// Sequencer: next state and character generation
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		fix_d     = fix_q;
		dot_d     = dot_q;
		ctl       = '0;
		push      = 1'b0;
		push_char = u2a_pkg::CHAR_ZERO;
		push_last = 1'b0;
		case (state_q)
			u2a_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (func)
						u2a_pkg::FUNC_DEC: begin
							ctl.load_bin = 1'b1;
							fix_d        = 1'b0;
							cnt_d        = STEP_W'(VW - 1);
							state_d      = u2a_pkg::ST_CONV;
						end
						u2a_pkg::FUNC_HEX: begin
							ctl.load_hex = 1'b1;
							fix_d        = 1'b0;
							state_d      = u2a_pkg::ST_SCAN;
						end
						u2a_pkg::FUNC_FIX: begin
							if (u2a_pkg::fix_over(value)) begin
								cnt_d   = STEP_W'(u2a_pkg::OVF_LEN - 1);
								state_d = u2a_pkg::ST_OVF;
							end else begin
								ctl.load_bin = 1'b1;
								fix_d        = 1'b1;
								cnt_d        = STEP_W'(VW - 1);
								state_d      = u2a_pkg::ST_CONV;
							end
						end
						default: begin
							state_d = u2a_pkg::ST_IDLE;
						end
					endcase
				end
			end
			u2a_pkg::ST_CONV: begin
				ctl.shift = 1'b1;
				if (cnt_q == '0)
					state_d = u2a_pkg::ST_SCAN;
				else
					cnt_d = cnt_q - 1'b1;
			end
			u2a_pkg::ST_SCAN: begin
				idx_d   = hi;
				dot_d   = 1'b0;
				state_d = u2a_pkg::ST_EMIT;
			end
			u2a_pkg::ST_EMIT: begin
				if (advance) begin
					push = 1'b1;
					if (fix_q && idx_q == '0 && !dot_q) begin
						push_char = u2a_pkg::CHAR_DOT;
						dot_d     = 1'b1;
					end else begin
						push_char = u2a_pkg::ascii_digit(digits[idx_q]);
						if (idx_q == '0) begin
							push_last = 1'b1;
							state_d   = u2a_pkg::ST_IDLE;
						end else begin
							idx_d = idx_q - 1'b1;
						end
					end
				end
			end
			u2a_pkg::ST_OVF: begin
				if (advance) begin
					push = 1'b1;
					if (cnt_q == STEP_W'(u2a_pkg::OVF_DOT_POS))
						push_char = u2a_pkg::CHAR_DOT;
					else
						push_char = u2a_pkg::CHAR_STAR;
					if (cnt_q == '0) begin
						push_last = 1'b1;
						state_d   = u2a_pkg::ST_IDLE;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = u2a_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2a_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			fix_q   <= 1'b0;
			dot_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			fix_q   <= fix_d;
			dot_q   <= dot_d;
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (push) begin
			char_q <= push_char;
			last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	// A decimal or hex transfer leaves the idle state
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == u2a_pkg::FUNC_DEC || func == u2a_pkg::FUNC_HEX)
		|=> !in_ready)
		else $error("formatter still idle after taking an item");

	// Emission index stays inside the digit store
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u2a_pkg::ST_EMIT |-> idx_q < IDX_W'(NDIG))
		else $error("digit index out of range");

	// A character with last set returns the sequencer to idle and is shown with last
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_last |=> state_q == u2a_pkg::ST_IDLE && out_valid && last)
		else $error("final character did not end the conversion");

	// No character is pushed while the output slot is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !push)
		else $error("output register overwritten during stall");

	// In fixed mode the digit being emitted is legal BCD
	a_bcd_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u2a_pkg::ST_EMIT && fix_q |-> digits[idx_q] <= 4'd9)
		else $error("illegal BCD digit in fixed mode");

endmodule

@@ test/tb_unsigned_to_ascii_formatter.sv @@
// Testbench for unsigned_to_ascii_formatter: random and directed number-to-text checks.
// Depends on u2a_pkg and the formatter RTL; the expected text is computed inside this file.
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_formatter;

	localparam int VW = u2a_pkg::VALUE_WIDTH;
	// Selector code the block takes but ignores
	localparam logic [1:0] FUNC_NONE = 2'd3;
	// Settle time after the last character (BCD pass plus scan plus margin)
	localparam int SETTLE_CYCLES = 60;
	// Length of the long output stall
	localparam int LONG_HOLD_CYCLES = 400;
	// Cap on printed mismatch lines
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic [1:0]    f;
		logic [VW-1:0] v;
	} fmt_req_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} char_exp_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_ready;
	logic [1:0]    func      = u2a_pkg::FUNC_DEC;
	logic [VW-1:0] value     = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [7:0]    char_code;
	logic          last;

	fmt_req_t  fmt_requests [$];
	char_exp_t exp_chars [$];
	int        err_count   = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	logic      in_xfer     = 1'b0;
	logic      hold_req    = 1'b0;
	logic      rx_hold     = 1'b0;

	unsigned_to_ascii_formatter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch @%0t: %s", $time, msg);
	endtask

	// Expected text of one conversion, pushed one character at a time
	task automatic predict_text(input logic [1:0] f, input logic [VW-1:0] v);
		logic [7:0]    text [$];
		logic [VW-1:0] num;
		logic [7:0]    d;
		int unsigned   radix;
		char_exp_t     e;
		if (f == FUNC_NONE)
			return;
		if (f == u2a_pkg::FUNC_FIX && v > u2a_pkg::FIX_LIMIT) begin
			text = '{u2a_pkg::CHAR_STAR, u2a_pkg::CHAR_DOT, u2a_pkg::CHAR_STAR,
				u2a_pkg::CHAR_STAR, u2a_pkg::CHAR_STAR};
		end else begin
			num   = (f == u2a_pkg::FUNC_FIX) ? v / 10 : v;
			radix = (f == u2a_pkg::FUNC_HEX) ? 16 : 10;
			// digits come out least significant first
			do begin
				d = 8'(num % radix);
				text.push_front((d < 8'd10) ? u2a_pkg::CHAR_ZERO + d
					: u2a_pkg::CHAR_A + d - 8'd10);
				num = num / radix;
			end while (num != 0);
			if (f == u2a_pkg::FUNC_FIX) begin
				text.push_back(u2a_pkg::CHAR_DOT);
				text.push_back(u2a_pkg::CHAR_ZERO + 8'(v % 10));
			end
		end
		foreach (text[i]) begin
			e.code = text[i];
			e.last = (i == text.size() - 1);
			exp_chars.push_back(e);
		end
	endtask

	// Handshake sampling, prediction and checking at the rising edge
	always @(posedge clk) begin: monitor
		char_exp_t e;
		in_xfer = arst_n && in_valid && in_ready;
		if (in_xfer)
			predict_text(func, value);
		if (arst_n && out_valid && out_ready) begin
			if (exp_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last %0b", char_code, last));
			end else begin
				e = exp_chars.pop_front();
				if (char_code !== e.code)
					report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
						char_code, e.code));
				if (last !== e.last)
					report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
						last, e.last, e.code));
			end
		end
	end

	// Input side: new item only after the previous transfer or from idle
	always @(negedge clk) begin: driver
		fmt_req_t req;
		if (!in_valid || in_xfer) begin
			if (arst_n && fmt_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				req = fmt_requests.pop_front();
				in_valid <= 1'b1;
				func     <= req.f;
				value    <= req.v;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side backpressure
	always @(negedge clk) begin: receiver
		if (rx_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Long output stall, counted here so the sender keeps pushing meanwhile
	always begin: long_hold
		wait (hold_req);
		rx_hold = 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		rx_hold  = 1'b0;
		hold_req = 1'b0;
	end

	task automatic add_req(input logic [1:0] f, input logic [VW-1:0] v);
		fmt_req_t r;
		r.f = f;
		r.v = v;
		fmt_requests.push_back(r);
	endtask

	function automatic logic [VW-1:0] pick_value(input logic [1:0] f);
		logic [VW-1:0] v;
		// random shift spreads the digit count
		v = $urandom >> $urandom_range(31, 0);
		if (f == u2a_pkg::FUNC_FIX) begin
			case ($urandom_range(9))
				0: v = $urandom;
				1: v = VW'(u2a_pkg::FIX_LIMIT - 2 + $urandom_range(4));
				2: v = VW'($urandom_range(12));
				default: v = VW'($urandom_range(u2a_pkg::FIX_LIMIT));
			endcase
		end
		return v;
	endfunction

	// Random conversions; ignored selectors do not count
	task automatic queue_random(input int n);
		logic [1:0] f;
		int         done;
		done = 0;
		while (done < n) begin
			if ($urandom_range(19) == 0) begin
				f = FUNC_NONE;
			end else begin
				f = 2'($urandom_range(2));
				done++;
			end
			add_req(f, pick_value(f));
		end
	endtask

	// Wait until every item is sent and every character seen, then let the block settle
	task automatic drain();
		while (fmt_requests.size() != 0 || in_valid || exp_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sender idles less than receiver
		tx_idle_pct = 32;
		rx_idle_pct = 80;
		// decimal extremes and digit count edges
		add_req(u2a_pkg::FUNC_DEC, 32'd0);
		add_req(u2a_pkg::FUNC_DEC, 32'd9);
		add_req(u2a_pkg::FUNC_DEC, 32'd10);
		add_req(u2a_pkg::FUNC_DEC, 32'd999999999);
		add_req(u2a_pkg::FUNC_DEC, 32'd1000000000);
		add_req(u2a_pkg::FUNC_DEC, 32'hFFFF_FFFF);
		// hex extremes, letters and digits
		add_req(u2a_pkg::FUNC_HEX, 32'h0);
		add_req(u2a_pkg::FUNC_HEX, 32'hF);
		add_req(u2a_pkg::FUNC_HEX, 32'h10);
		add_req(u2a_pkg::FUNC_HEX, 32'hABCD_EF01);
		add_req(u2a_pkg::FUNC_HEX, 32'h1000_0000);
		add_req(u2a_pkg::FUNC_HEX, 32'hFFFF_FFFF);
		// fixed point: zero, fraction only, limit and overflow
		add_req(u2a_pkg::FUNC_FIX, 32'd0);
		add_req(u2a_pkg::FUNC_FIX, 32'd5);
		add_req(u2a_pkg::FUNC_FIX, 32'd10);
		add_req(u2a_pkg::FUNC_FIX, 32'd9999);
		add_req(u2a_pkg::FUNC_FIX, 32'd10000);
		add_req(u2a_pkg::FUNC_FIX, 32'd12345);
		add_req(u2a_pkg::FUNC_FIX, 32'hFFFF_FFFF);
		// ignored selector between real ones
		add_req(FUNC_NONE, 32'hFFFF_FFFF);
		add_req(u2a_pkg::FUNC_DEC, 32'd42);
		add_req(FUNC_NONE, 32'd0);
		add_req(u2a_pkg::FUNC_HEX, 32'h5A);
		queue_random(65);
		drain();

		// Output held off while the sender keeps offering
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		queue_random(20);
		drain();

		// Receiver idles less than sender
		tx_idle_pct = 80;
		rx_idle_pct = 32;
		queue_random(75);
		drain();

		// Back to back
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(75);
		drain();

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/u2a_pkg.sv
rtl/u2a_dabble.sv
rtl/unsigned_to_ascii_formatter.sv
test/tb_unsigned_to_ascii_formatter.sv
